// ===== sv/rsos_pkg.sv =====
package rsos_pkg;

    // Fixed field widths
    localparam int ANGLE_W = 8;
    localparam int DIST_W  = 16;
    localparam int SUM_W   = 24;
    localparam int CNT_W   = 8;

    localparam logic [ANGLE_W-1:0] ANGLE_MAX    = 8'd180;
    localparam logic [ANGLE_W-1:0] TAN_SPAN_MAX = 8'd178;
    localparam logic [CNT_W-1:0]   CNT_MAX      = 8'd255;

    // Reset values of the configuration registers
    localparam logic [DIST_W-1:0] THRESHOLD_RESET = 16'd1280;
    localparam logic [15:0]       LIMIT_RESET     = 16'd10;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH_LIMIT = 2'd1;

    // Fixed-point constants of the tangent series
    localparam logic [31:0] Q28_ONE     = 32'h1000_0000;
    localparam logic [15:0] RAD_SCALE   = 16'd314;
    localparam logic [31:0] RAD_DIVISOR = 32'd36000;
    localparam int          SERIES_TERMS = 10;
    localparam logic [17:0] TAN_Q10_MAX = 18'h3FFFF;
    localparam logic [31:0] WIDTH_DIV   = 32'd5;

    // Shared serial arithmetic unit
    localparam int ALU_A_W   = 64;
    localparam int ALU_B_W   = 32;
    localparam int ALU_CNT_W = 7;
    localparam logic [ALU_CNT_W-1:0] MUL_STEPS = 7'd32;
    localparam logic [ALU_CNT_W-1:0] DIV_STEPS = 7'd64;

    typedef enum logic {
        ALU_MUL,
        ALU_DIV
    } t_alu_op;

    typedef struct packed {
        logic               start;
        t_alu_op            op;
        logic [ALU_A_W-1:0] a;
        logic [ALU_B_W-1:0] b;
    } t_alu_req;

    typedef struct packed {
        logic               done;
        logic [ALU_A_W-1:0] result;
    } t_alu_rsp;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MEAN,
        ST_XDIV,
        ST_X2,
        ST_TS_MUL,
        ST_TS_DIV,
        ST_TC_MUL,
        ST_TC_DIV,
        ST_QUOT,
        ST_WMUL,
        ST_WDIV,
        ST_EMIT
    } t_state;

    // (2n)(2n+1): divisor of the n-th sine term
    function automatic logic [8:0] sin_den(input logic [3:0] n);
        logic [8:0] d;
        unique case (n)
            4'd1:    d = 9'd6;
            4'd2:    d = 9'd20;
            4'd3:    d = 9'd42;
            4'd4:    d = 9'd72;
            4'd5:    d = 9'd110;
            4'd6:    d = 9'd156;
            4'd7:    d = 9'd210;
            4'd8:    d = 9'd272;
            4'd9:    d = 9'd342;
            4'd10:   d = 9'd420;
            default: d = 9'd1;
        endcase
        return d;
    endfunction

    // (2n-1)(2n): divisor of the n-th cosine term
    function automatic logic [8:0] cos_den(input logic [3:0] n);
        logic [8:0] d;
        unique case (n)
            4'd1:    d = 9'd2;
            4'd2:    d = 9'd12;
            4'd3:    d = 9'd30;
            4'd4:    d = 9'd56;
            4'd5:    d = 9'd90;
            4'd6:    d = 9'd132;
            4'd7:    d = 9'd182;
            4'd8:    d = 9'd240;
            4'd9:    d = 9'd306;
            4'd10:   d = 9'd380;
            default: d = 9'd1;
        endcase
        return d;
    endfunction

endpackage

// ===== sv/rsos_serial_alu.sv =====
module rsos_serial_alu (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rsos_pkg::t_alu_req i_req,
    output rsos_pkg::t_alu_rsp o_rsp
);
    import rsos_pkg::*;

    logic                 r_busy, n_busy;
    logic                 r_done, n_done;
    t_alu_op              r_op, n_op;
    logic [ALU_CNT_W-1:0] r_cnt, n_cnt;
    logic [ALU_B_W-1:0]   r_hi, n_hi;
    logic [ALU_A_W-1:0]   r_lo, n_lo;
    logic [ALU_B_W-1:0]   r_b, n_b;
    logic [ALU_B_W:0]     sum_step;
    logic [ALU_B_W:0]     rem_step;
    logic                 q_bit;

    // One bit per cycle: shift-add multiply, restoring divide
    always_comb begin
        n_busy   = r_busy;
        n_done   = 1'b0;
        n_op     = r_op;
        n_cnt    = r_cnt;
        n_hi     = r_hi;
        n_lo     = r_lo;
        n_b      = r_b;
        sum_step = {1'b0, r_hi} + (r_lo[0] ? {1'b0, r_b} : '0);
        rem_step = {r_hi, r_lo[ALU_A_W-1]};
        q_bit    = (rem_step >= {1'b0, r_b});
        if (r_busy) begin
            unique case (r_op)
                ALU_MUL: begin
                    n_hi = sum_step[ALU_B_W:1];
                    n_lo = {sum_step[0], r_lo[ALU_A_W-1:1]};
                end
                ALU_DIV: begin
                    n_hi = q_bit ? ALU_B_W'(rem_step - {1'b0, r_b}) : rem_step[ALU_B_W-1:0];
                    n_lo = {r_lo[ALU_A_W-2:0], q_bit};
                end
            endcase
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == ALU_CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end else if (i_req.start) begin
            n_busy = 1'b1;
            n_op   = i_req.op;
            n_b    = i_req.b;
            n_hi   = '0;
            if (i_req.op == ALU_MUL) begin
                n_cnt = MUL_STEPS;
                n_lo  = {{(ALU_A_W-ALU_B_W){1'b0}}, i_req.a[ALU_B_W-1:0]};
            end else begin
                n_cnt = DIV_STEPS;
                n_lo  = i_req.a;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_op <= n_op;
        r_hi <= n_hi;
        r_lo <= n_lo;
        r_b  <= n_b;
    end

    assign o_rsp.done   = r_done;
    assign o_rsp.result = (r_op == ALU_MUL) ? {r_hi, r_lo[ALU_A_W-1:ALU_B_W]} : r_lo;

    a_no_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |-> !r_busy)
        else $error("operation started while the unit is busy");

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy && $past(r_busy))
        else $error("done without a finished operation");

    a_busy_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_cnt != '0)
        else $error("busy with no steps left");

endmodule

// ===== sv/range_sweep_object_segmenter.sv =====
// Range sweep object segmenter.
// Input channel (i_in_valid / o_in_stall) takes one sweep sample per item: angle, ping
// and IR distance in 1/16 cm, and a first-of-sweep flag that clears segment state and
// object numbering. An IR distance below detect_threshold opens or extends an object;
// the first later sample at or above it closes the object.
// Output channel (o_out_valid / i_out_stall) carries one item per closed object: its
// number, first, last and middle angle, mean ping distance, width in cm, ideal flag.
// Configuration: i_cfg_valid with index and data; o_cfg_ready is always high.
// Index 0 is detect_threshold, index 1 ideal_width_limit; other indexes are ignored.
// Rate: a sample that does not close an object is taken while idle, so such samples flow
// back to back. A closing sample holds the input while the mean division, the Q28
// tangent series (ten sine and ten cosine terms) and the width all run through one
// bit-serial multiply/divide unit. The result then sits in the output register; the
// next sample is accepted while it waits, but a further close holds until the output
// register is free.
// Reset (synchronous, active low) loads the register defaults (threshold 1280,
// limit 10), clears all segment state and drops any pending output item.
module range_sweep_object_segmenter (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_first_of_sweep,
    input  logic [7:0]         i_angle,
    input  logic [15:0]        i_ping_distance,
    input  logic [15:0]        i_ir_distance,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [7:0]         o_object_number,
    output logic [7:0]         o_first_angle,
    output logic [7:0]         o_last_angle,
    output logic [7:0]         o_middle_angle,
    output logic [15:0]        o_mean_distance,
    output logic signed [15:0] o_width_cm,
    output logic               o_ideal,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data
);
    import rsos_pkg::*;

    t_state r_state, n_state;

    // Configuration
    logic [DIST_W-1:0] r_thr, n_thr;
    logic [15:0]       r_limit, n_limit;

    // Segment state
    logic               r_in_object, n_in_object;
    logic [ANGLE_W-1:0] r_begin, n_begin;
    logic [SUM_W-1:0]   r_sum, n_sum;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [CNT_W-1:0]   r_objcnt, n_objcnt;

    // Snapshot of the object being finished
    logic [7:0]         r_job_num, n_job_num;
    logic [ANGLE_W-1:0] r_job_first, n_job_first;
    logic [ANGLE_W-1:0] r_job_last, n_job_last;
    logic [ANGLE_W-1:0] r_job_mid, n_job_mid;
    logic [ANGLE_W-1:0] r_job_k, n_job_k;
    logic               r_job_neg, n_job_neg;
    logic [SUM_W-1:0]   r_job_sum, n_job_sum;
    logic [CNT_W-1:0]   r_job_cnt, n_job_cnt;

    // Arithmetic working registers
    logic               r_issued, n_issued;
    logic [DIST_W-1:0]  r_mean, n_mean;
    logic [31:0]        r_x, n_x;
    logic [31:0]        r_x2, n_x2;
    logic [31:0]        r_ts, n_ts;
    logic [31:0]        r_tc, n_tc;
    logic signed [31:0] r_s, n_s;
    logic signed [31:0] r_c, n_c;
    logic [3:0]         r_n, n_n;
    logic [35:0]        r_tmp, n_tmp;
    logic [17:0]        r_tan, n_tan;
    logic [15:0]        r_width, n_width;
    logic               r_ideal, n_ideal;

    // Output register
    logic               r_out_valid, n_out_valid;
    logic [7:0]         r_out_num, n_out_num;
    logic [7:0]         r_out_first, n_out_first;
    logic [7:0]         r_out_last, n_out_last;
    logic [7:0]         r_out_mid, n_out_mid;
    logic [15:0]        r_out_mean, n_out_mean;
    logic [15:0]        r_out_width, n_out_width;
    logic               r_out_ideal, n_out_ideal;

    t_alu_req alu_req;
    t_alu_rsp alu_rsp;

    // Sample decode
    logic               in_accept;
    logic [ANGLE_W-1:0] ang;
    logic               eff_in_object;
    logic [ANGLE_W-1:0] eff_begin;
    logic [SUM_W-1:0]   eff_sum;
    logic [CNT_W-1:0]   eff_count;
    logic [CNT_W-1:0]   eff_objcnt;
    logic [ANGLE_W:0]   span;
    logic [ANGLE_W+1:0] k_full;
    logic [ANGLE_W+1:0] k_mag;
    logic [15:0]        k_rad;
    logic [39:0]        p22;
    logic [63:0]        q;

    rsos_serial_alu u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (alu_req),
        .o_rsp   (alu_rsp)
    );

    assign o_in_stall = (r_state != ST_IDLE);
    assign in_accept  = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    // Clamp the angle and apply a sweep restart ahead of the sample
    always_comb begin
        ang           = (i_angle > ANGLE_MAX) ? ANGLE_MAX : i_angle;
        eff_in_object = i_first_of_sweep ? 1'b0 : r_in_object;
        eff_begin     = i_first_of_sweep ? '0 : r_begin;
        eff_sum       = i_first_of_sweep ? '0 : r_sum;
        eff_count     = i_first_of_sweep ? '0 : r_count;
        eff_objcnt    = i_first_of_sweep ? '0 : r_objcnt;
        span          = {1'b0, ang} - {1'b0, eff_begin};
        k_full        = {span[ANGLE_W], span} - (ANGLE_W+2)'(2);
        k_mag         = k_full[ANGLE_W+1] ? (ANGLE_W+2)'(-k_full) : k_full;
        k_rad         = {8'd0, r_job_k} * RAD_SCALE;
        p22           = {r_tmp, 4'b0} + {2'b0, r_tmp, 2'b0} + {3'b0, r_tmp, 1'b0};
        q             = alu_rsp.result;
    end

    always_comb begin
        n_state     = r_state;
        n_thr       = r_thr;
        n_limit     = r_limit;
        n_in_object = r_in_object;
        n_begin     = r_begin;
        n_sum       = r_sum;
        n_count     = r_count;
        n_objcnt    = r_objcnt;
        n_job_num   = r_job_num;
        n_job_first = r_job_first;
        n_job_last  = r_job_last;
        n_job_mid   = r_job_mid;
        n_job_k     = r_job_k;
        n_job_neg   = r_job_neg;
        n_job_sum   = r_job_sum;
        n_job_cnt   = r_job_cnt;
        n_issued    = r_issued;
        n_mean      = r_mean;
        n_x         = r_x;
        n_x2        = r_x2;
        n_ts        = r_ts;
        n_tc        = r_tc;
        n_s         = r_s;
        n_c         = r_c;
        n_n         = r_n;
        n_tmp       = r_tmp;
        n_tan       = r_tan;
        n_width     = r_width;
        n_ideal     = r_ideal;
        n_out_valid = r_out_valid;
        n_out_num   = r_out_num;
        n_out_first = r_out_first;
        n_out_last  = r_out_last;
        n_out_mid   = r_out_mid;
        n_out_mean  = r_out_mean;
        n_out_width = r_out_width;
        n_out_ideal = r_out_ideal;
        alu_req     = '{start: 1'b0, op: ALU_MUL, a: '0, b: '0};

        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_THRESHOLD:   n_thr   = i_cfg_data;
                CFG_WIDTH_LIMIT: n_limit = i_cfg_data;
                default: ;
            endcase
        end

        // Drop the output item once the receiver takes it
        if (r_out_valid && !i_out_stall)
            n_out_valid = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (in_accept) begin
                    n_in_object = eff_in_object;
                    n_begin     = eff_begin;
                    n_sum       = eff_sum;
                    n_count     = eff_count;
                    n_objcnt    = eff_objcnt;
                    if (i_ir_distance < r_thr) begin
                        if (!eff_in_object) begin
                            n_in_object = 1'b1;
                            n_begin     = ang;
                            n_sum       = {{(SUM_W-DIST_W){1'b0}}, i_ping_distance};
                            n_count     = CNT_W'(1);
                        end else if (eff_count < CNT_MAX) begin
                            n_sum   = eff_sum + {{(SUM_W-DIST_W){1'b0}}, i_ping_distance};
                            n_count = eff_count + 1'b1;
                        end
                    end else if (eff_in_object) begin
                        // Close the object and hand it to the sequencer
                        n_objcnt    = (eff_objcnt < CNT_MAX) ? eff_objcnt + 1'b1 : eff_objcnt;
                        n_job_num   = n_objcnt;
                        n_job_first = eff_begin;
                        n_job_last  = ang;
                        n_job_mid   = eff_begin + span[ANGLE_W:1];
                        n_job_neg   = k_full[ANGLE_W+1];
                        n_job_k     = (k_mag > {2'b0, TAN_SPAN_MAX}) ? TAN_SPAN_MAX
                                                                     : k_mag[ANGLE_W-1:0];
                        n_job_sum   = eff_sum;
                        n_job_cnt   = eff_count;
                        n_in_object = 1'b0;
                        n_sum       = '0;
                        n_count     = '0;
                        n_state     = ST_MEAN;
                    end
                end
            end
            ST_MEAN: begin
                if (r_job_cnt == '0) begin
                    n_mean  = '0;
                    n_state = ST_XDIV;
                end else begin
                    alu_req = '{start: !r_issued, op: ALU_DIV,
                                a: {{(ALU_A_W-SUM_W){1'b0}}, r_job_sum},
                                b: {{(ALU_B_W-CNT_W){1'b0}}, r_job_cnt}};
                    n_issued = 1'b1;
                    if (alu_rsp.done) begin
                        n_issued = 1'b0;
                        n_mean   = q[DIST_W-1:0];
                        n_state  = ST_XDIV;
                    end
                end
            end
            ST_XDIV: begin
                // Half-angle in Q28 radians
                alu_req = '{start: !r_issued, op: ALU_DIV,
                            a: {20'b0, k_rad, 28'b0}, b: RAD_DIVISOR};
                n_issued = 1'b1;
                if (alu_rsp.done) begin
                    n_issued = 1'b0;
                    n_x      = q[31:0];
                    n_state  = ST_X2;
                end
            end
            ST_X2: begin
                alu_req = '{start: !r_issued, op: ALU_MUL, a: {32'b0, r_x}, b: r_x};
                n_issued = 1'b1;
                if (alu_rsp.done) begin
                    n_issued = 1'b0;
                    n_x2     = q[59:28];
                    n_ts     = r_x;
                    n_tc     = Q28_ONE;
                    n_s      = $signed(r_x);
                    n_c      = $signed(Q28_ONE);
                    n_n      = 4'd1;
                    n_state  = ST_TS_MUL;
                end
            end
            ST_TS_MUL: begin
                alu_req = '{start: !r_issued, op: ALU_MUL, a: {32'b0, r_ts}, b: r_x2};
                n_issued = 1'b1;
                if (alu_rsp.done) begin
                    n_issued = 1'b0;
                    n_tmp    = q[63:28];
                    n_state  = ST_TS_DIV;
                end
            end
            ST_TS_DIV: begin
                alu_req = '{start: !r_issued, op: ALU_DIV, a: {28'b0, r_tmp},
                            b: {23'b0, sin_den(r_n)}};
                n_issued = 1'b1;
                if (alu_rsp.done) begin
                    n_issued = 1'b0;
                    n_ts     = q[31:0];
                    n_state  = ST_TC_MUL;
                end
            end
            ST_TC_MUL: begin
                alu_req = '{start: !r_issued, op: ALU_MUL, a: {32'b0, r_tc}, b: r_x2};
                n_issued = 1'b1;
                if (alu_rsp.done) begin
                    n_issued = 1'b0;
                    n_tmp    = q[63:28];
                    n_state  = ST_TC_DIV;
                end
            end
            ST_TC_DIV: begin
                alu_req = '{start: !r_issued, op: ALU_DIV, a: {28'b0, r_tmp},
                            b: {23'b0, cos_den(r_n)}};
                n_issued = 1'b1;
                if (alu_rsp.done) begin
                    n_issued = 1'b0;
                    n_tc     = q[31:0];
                    // Odd terms subtract, even terms add
                    if (r_n[0]) begin
                        n_s = r_s - $signed(r_ts);
                        n_c = r_c - $signed(q[31:0]);
                    end else begin
                        n_s = r_s + $signed(r_ts);
                        n_c = r_c + $signed(q[31:0]);
                    end
                    if (r_n == 4'(SERIES_TERMS)) begin
                        n_state = ST_QUOT;
                    end else begin
                        n_n     = r_n + 1'b1;
                        n_state = ST_TS_MUL;
                    end
                end
            end
            ST_QUOT: begin
                if (r_c <= 32'sd0 || r_s < 32'sd0) begin
                    n_tan   = TAN_Q10_MAX;
                    n_state = ST_WMUL;
                end else begin
                    // Q10 tangent, rounded to nearest
                    alu_req = '{start: !r_issued, op: ALU_DIV,
                                a: {22'b0, r_s, 10'b0} + {33'b0, r_c[31:1]}, b: r_c};
                    n_issued = 1'b1;
                    if (alu_rsp.done) begin
                        n_issued = 1'b0;
                        n_tan    = (q > {46'b0, TAN_Q10_MAX}) ? TAN_Q10_MAX : q[17:0];
                        n_state  = ST_WMUL;
                    end
                end
            end
            ST_WMUL: begin
                alu_req = '{start: !r_issued, op: ALU_MUL, a: {46'b0, r_tan},
                            b: {16'b0, r_mean}};
                n_issued = 1'b1;
                if (alu_rsp.done) begin
                    n_issued = 1'b0;
                    n_tmp    = q[35:0];
                    n_state  = ST_WDIV;
                end
            end
            ST_WDIV: begin
                // tan * mean * 2.2 / (1024 * 16) = (P * 22 >> 15) / 5
                alu_req = '{start: !r_issued, op: ALU_DIV, a: {39'b0, p22[39:15]},
                            b: WIDTH_DIV};
                n_issued = 1'b1;
                if (alu_rsp.done) begin
                    n_issued = 1'b0;
                    if (!r_job_neg) begin
                        n_width = (q > 64'd32767) ? 16'h7FFF : q[15:0];
                    end else begin
                        n_width = (q > 64'd32768) ? 16'h8000 : 16'(~q[15:0] + 16'd1);
                    end
                    n_ideal = !n_width[15] && (n_width != '0) && (n_width < r_limit);
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                // Hold until the output register is free
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_out_num   = r_job_num;
                    n_out_first = r_job_first;
                    n_out_last  = r_job_last;
                    n_out_mid   = r_job_mid;
                    n_out_mean  = r_mean;
                    n_out_width = r_width;
                    n_out_ideal = r_ideal;
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_thr       <= THRESHOLD_RESET;
            r_limit     <= LIMIT_RESET;
            r_in_object <= 1'b0;
            r_begin     <= '0;
            r_sum       <= '0;
            r_count     <= '0;
            r_objcnt    <= '0;
            r_issued    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_thr       <= n_thr;
            r_limit     <= n_limit;
            r_in_object <= n_in_object;
            r_begin     <= n_begin;
            r_sum       <= n_sum;
            r_count     <= n_count;
            r_objcnt    <= n_objcnt;
            r_issued    <= n_issued;
            r_out_valid <= n_out_valid;
        end
        r_job_num   <= n_job_num;
        r_job_first <= n_job_first;
        r_job_last  <= n_job_last;
        r_job_mid   <= n_job_mid;
        r_job_k     <= n_job_k;
        r_job_neg   <= n_job_neg;
        r_job_sum   <= n_job_sum;
        r_job_cnt   <= n_job_cnt;
        r_mean      <= n_mean;
        r_x         <= n_x;
        r_x2        <= n_x2;
        r_ts        <= n_ts;
        r_tc        <= n_tc;
        r_s         <= n_s;
        r_c         <= n_c;
        r_n         <= n_n;
        r_tmp       <= n_tmp;
        r_tan       <= n_tan;
        r_width     <= n_width;
        r_ideal     <= n_ideal;
        r_out_num   <= n_out_num;
        r_out_first <= n_out_first;
        r_out_last  <= n_out_last;
        r_out_mid   <= n_out_mid;
        r_out_mean  <= n_out_mean;
        r_out_width <= n_out_width;
        r_out_ideal <= n_out_ideal;
    end

    assign o_out_valid     = r_out_valid;
    assign o_object_number = r_out_num;
    assign o_first_angle   = r_out_first;
    assign o_last_angle    = r_out_last;
    assign o_middle_angle  = r_out_mid;
    assign o_mean_distance = r_out_mean;
    assign o_width_cm      = $signed(r_out_width);
    assign o_ideal         = r_out_ideal;

    a_open_has_samples: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_object == (r_count != '0))
        else $error("open object and sample count disagree");

    a_alu_from_sequencer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        alu_req.start |-> r_state != ST_IDLE && r_state != ST_EMIT)
        else $error("arithmetic started outside the object sequence");

    a_middle_between: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_middle_angle >= o_first_angle && o_middle_angle <= o_last_angle)
                     || (o_middle_angle <= o_first_angle && o_middle_angle >= o_last_angle))
        else $error("middle angle outside the object span");

    a_ideal_positive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_ideal |-> !o_width_cm[15] && o_width_cm != 16'sd0)
        else $error("ideal flag on a width that is not positive");

endmodule

// ===== verif/range_sweep_object_segmenter_test.sv =====
`timescale 1ns / 1ps

module range_sweep_object_segmenter_test;
    import rsos_pkg::*;

    // Spare register indexes: the block ignores writes to them
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    // The settle time covers the busy period of a closing sample
    localparam int SETTLE_CYCLES = 3000;
    localparam int CYCLE_LIMIT   = 20_000_000;
    localparam int IDLE_PERCENT  = 14;

    // One closed object as the block reports it
    typedef struct {
        logic [ANGLE_W-1:0]  number;
        logic [ANGLE_W-1:0]  start_ang;
        logic [ANGLE_W-1:0]  end_ang;
        logic [ANGLE_W-1:0]  mid_ang;
        logic [DIST_W-1:0]   mean;
        logic signed [15:0]  width;
        logic                ideal;
    } t_segment;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_stall;
    logic               i_first_of_sweep;
    logic [7:0]         i_angle;
    logic [15:0]        i_ping_distance;
    logic [15:0]        i_ir_distance;
    logic               o_out_valid;
    logic               i_out_stall;
    logic [7:0]         o_object_number;
    logic [7:0]         o_first_angle;
    logic [7:0]         o_last_angle;
    logic [7:0]         o_middle_angle;
    logic [15:0]        o_mean_distance;
    logic signed [15:0] o_width_cm;
    logic               o_ideal;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [1:0]         i_cfg_index;
    logic [15:0]        i_cfg_data;

    range_sweep_object_segmenter u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_first_of_sweep (i_first_of_sweep),
        .i_angle          (i_angle),
        .i_ping_distance  (i_ping_distance),
        .i_ir_distance    (i_ir_distance),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_object_number  (o_object_number),
        .o_first_angle    (o_first_angle),
        .o_last_angle     (o_last_angle),
        .o_middle_angle   (o_middle_angle),
        .o_mean_distance  (o_mean_distance),
        .o_width_cm       (o_width_cm),
        .o_ideal          (o_ideal),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    // Segment tracker: the block's registers and per-sweep state
    logic [DIST_W-1:0]  detect_threshold = THRESHOLD_RESET;
    logic [15:0]        width_limit      = LIMIT_RESET;
    logic               in_object        = 1'b0;
    logic [ANGLE_W-1:0] open_angle       = '0;
    logic [SUM_W-1:0]   ping_sum         = '0;
    logic [CNT_W-1:0]   ping_count       = '0;
    logic [CNT_W-1:0]   objects_closed   = '0;

    t_segment expected_segments[$];

    int  error_count     = 0;
    int  samples_sent    = 0;
    int  segments_seen   = 0;
    int  register_writes = 0;
    int  cycle_count     = 0;
    bit  idle_on         = 1'b1;
    logic [ANGLE_W-1:0] sweep_ang = '0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Stop a hung run
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("range_sweep_object_segmenter_test NOT OK");
        $finish;
    end

    function automatic bit idle_roll();
        return idle_on && ($urandom_range(99) < IDLE_PERCENT);
    endfunction

    // tan(3.14/180 * k/2) in Q8.10 from Q28 sine and cosine series
    function automatic longint unsigned tan_half_span_q10(input int unsigned k);
        longint unsigned x, x2, ts, tc, r, n;
        longint          s, c;
        int unsigned     k_lim;
        k_lim = (k > 32'(TAN_SPAN_MAX)) ? 32'(TAN_SPAN_MAX) : k;
        x  = 64'(k_lim);
        x  = ((x * RAD_SCALE) << 28) / RAD_DIVISOR;
        x2 = (x * x) >> 28;
        ts = x;
        tc = 64'(Q28_ONE);
        s  = x;
        c  = 64'(Q28_ONE);
        for (n = 1; n <= SERIES_TERMS; n++) begin
            ts = ((ts * x2) >> 28) / ((2 * n) * (2 * n + 1));
            tc = ((tc * x2) >> 28) / ((2 * n - 1) * (2 * n));
            if (n[0]) begin
                s = s - longint'(ts);
                c = c - longint'(tc);
            end else begin
                s = s + longint'(ts);
                c = c + longint'(tc);
            end
        end
        if (c <= 0 || s < 0)
            return 64'(TAN_Q10_MAX);
        r = ($unsigned(s) * 1024 + $unsigned(c) / 2) / $unsigned(c);
        return (r > TAN_Q10_MAX) ? 64'(TAN_Q10_MAX) : r;
    endfunction

    // Advance the tracker by one accepted sample; queue a segment on close
    task automatic track_sample(input logic first_flag, input logic [7:0] ang_in,
                                input logic [15:0] ping, input logic [15:0] ir);
        logic [ANGLE_W-1:0] ang;
        int                 span, half, k, width;
        longint unsigned    mean, tq, mag;
        t_segment           seg;
        if (first_flag) begin
            in_object      = 1'b0;
            open_angle     = '0;
            ping_sum       = '0;
            ping_count     = '0;
            objects_closed = '0;
        end
        ang = (ang_in > ANGLE_MAX) ? ANGLE_MAX : ang_in;
        if (ir < detect_threshold) begin
            if (!in_object) begin
                in_object  = 1'b1;
                open_angle = ang;
                ping_sum   = SUM_W'(ping);
                ping_count = CNT_W'(1);
            end else if (ping_count < CNT_MAX) begin
                ping_sum   = ping_sum + SUM_W'(ping);
                ping_count = ping_count + 1'b1;
            end
        end else if (in_object) begin
            span = int'(ang) - int'(open_angle);
            half = (span >= 0) ? span / 2 : -((-span + 1) / 2);
            k    = span - 2;
            mean = (ping_count != 0) ? ping_sum / ping_count : 0;
            tq   = tan_half_span_q10((k < 0) ? -k : k);
            mag  = (tq * mean * 22) / (16384 * 10);
            if (k >= 0)
                width = (mag > 32767) ? 32767 : int'(mag);
            else
                width = (mag > 32768) ? -32768 : -int'(mag);
            if (objects_closed < CNT_MAX)
                objects_closed = objects_closed + 1'b1;
            in_object     = 1'b0;
            seg.number    = objects_closed;
            seg.start_ang = open_angle;
            seg.end_ang   = ang;
            seg.mid_ang   = 8'(int'(open_angle) + half);
            seg.mean      = mean[DIST_W-1:0];
            seg.width     = width[15:0];
            seg.ideal     = (width > 0) && (width < int'(width_limit));
            expected_segments.push_back(seg);
            ping_sum   = '0;
            ping_count = '0;
        end
    endtask

    // Offer one sample after a random gap; hold it until accepted
    task automatic send_sample(input logic first_flag, input logic [7:0] ang,
                               input logic [15:0] ping, input logic [15:0] ir);
        while (idle_roll()) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_in_valid       <= 1'b1;
        i_first_of_sweep <= first_flag;
        i_angle          <= ang;
        i_ping_distance  <= ping;
        i_ir_distance    <= ir;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        track_sample(first_flag, ang, ping, ir);
        samples_sent++;
    endtask

    // Write one register; the block must be idle
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        case (idx)
            CFG_THRESHOLD:   detect_threshold = data;
            CFG_WIDTH_LIMIT: width_limit      = data;
            default: ;
        endcase
        register_writes++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Drop valid, drain every expected segment, then let the block settle
    task automatic wait_idle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (expected_segments.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [15:0] inside_ir();
        return 16'($urandom_range(int'(detect_threshold) - 1, 0));
    endfunction

    function automatic logic [15:0] outside_ir();
        return 16'($urandom_range(65535, int'(detect_threshold)));
    endfunction

    // Mix of full-range and short distances so narrow objects show up
    function automatic logic [15:0] ping_roll();
        return $urandom_range(1) ? 16'($urandom_range(65535)) : 16'($urandom_range(2000));
    endfunction

    // Step the sweep angle forward; wrap into a new sweep past the end
    task automatic send_swept(input logic [15:0] ping, input logic [15:0] ir);
        int   a;
        logic first_flag;
        a          = int'(sweep_ang) + $urandom_range(3);
        first_flag = 1'b0;
        if (a > ANGLE_MAX) begin
            a          = 0;
            first_flag = 1'b1;
        end
        sweep_ang = 8'(a);
        send_sample(first_flag, 8'(a), ping, ir);
    endtask

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got) begin
            error_count++;
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    // Compare every accepted output item with the oldest expected segment
    always @(posedge i_clk) begin
        t_segment want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_segments.size() == 0) begin
                error_count++;
                $display("%0t: unexpected object item: expected none, actual number %0d",
                         $time, o_object_number);
            end else begin
                want = expected_segments.pop_front();
                check_field("object_number", want.number,    o_object_number);
                check_field("first_angle",   want.start_ang, o_first_angle);
                check_field("last_angle",    want.end_ang,   o_last_angle);
                check_field("middle_angle",  want.mid_ang,   o_middle_angle);
                check_field("mean_distance", want.mean,      o_mean_distance);
                check_field("width_cm",      want.width,     o_width_cm);
                check_field("ideal",         want.ideal,     o_ideal);
                segments_seen++;
            end
        end
    end

    // Stall the output side at random, changing on every cycle
    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            i_out_stall <= idle_roll();
        end
    end

    // Reset values: threshold 1280 and limit 10 before any write
    task automatic test_reset_defaults();
        send_sample(1'b1, 8'd10, 16'd100, 16'd1280);    // at threshold: no object
        send_sample(1'b0, 8'd12, 16'd0, 16'd1279);      // open just below threshold
        send_sample(1'b0, 8'd14, 16'hFFFF, 16'd0);
        send_sample(1'b0, 8'd16, 16'd16, 16'd1280);     // close at threshold
        // narrow object at 50 cm: width of a few cm, flagged ideal
        send_sample(1'b0, 8'd20, 16'd800, 16'd5);
        send_sample(1'b0, 8'd23, 16'd800, 16'd6);
        send_sample(1'b0, 8'd26, 16'd800, 16'd2000);
    endtask

    // Short, negative, descending, full and clamped spans
    task automatic test_span_cases();
        send_sample(1'b0, 8'd30, 16'd320, 16'd0);       // single-sample object
        send_sample(1'b0, 8'd30, 16'd320, 16'd4000);
        send_sample(1'b0, 8'd40, 16'd500, 16'd0);       // span of one
        send_sample(1'b0, 8'd41, 16'd500, 16'd5000);
        send_sample(1'b0, 8'd50, 16'd900, 16'd0);       // zero tangent
        send_sample(1'b0, 8'd52, 16'd900, 16'd5000);
        send_sample(1'b0, 8'd101, 16'd700, 16'd0);      // odd descending span
        send_sample(1'b0, 8'd100, 16'd700, 16'd5000);
        send_sample(1'b0, 8'd100, 16'd1200, 16'd0);     // descending object
        send_sample(1'b0, 8'd90, 16'd1300, 16'd3);
        send_sample(1'b0, 8'd80, 16'd0, 16'hFFFF);
        send_sample(1'b0, 8'd0, 16'hFFFF, 16'd0);       // full span: width saturates
        send_sample(1'b0, 8'd180, 16'd0, 16'd9000);
        send_sample(1'b0, 8'd200, 16'hFFFF, 16'd0);     // above range: taken as 180
        send_sample(1'b0, 8'd255, 16'hFFFF, 16'd0);
        send_sample(1'b0, 8'd0, 16'd0, 16'd9000);       // clamped negative span
    endtask

    // First-of-sweep clears an open object and the numbering
    task automatic test_sweep_restart();
        send_sample(1'b0, 8'd60, 16'd400, 16'd0);
        send_sample(1'b1, 8'd0, 16'd400, 16'd60000);    // drop open object, no item
        send_sample(1'b0, 8'd5, 16'd400, 16'd0);
        send_sample(1'b1, 8'd10, 16'd450, 16'd0);       // restart opens a new object
        send_sample(1'b0, 8'd15, 16'd450, 16'd9000);
    endtask

    // Register extremes and writes to the spare indexes
    task automatic test_register_extremes();
        wait_idle();
        write_register(CFG_THRESHOLD, 16'd0);           // nothing can lie below zero
        send_sample(1'b0, 8'd20, 16'd100, 16'd0);
        send_sample(1'b0, 8'd25, 16'd100, 16'hFFFF);
        wait_idle();
        write_register(CFG_THRESHOLD, 16'hFFFF);
        write_register(CFG_WIDTH_LIMIT, 16'd0);         // ideal can never be set
        send_sample(1'b0, 8'd30, 16'd640, 16'hFFFE);
        send_sample(1'b0, 8'd40, 16'd640, 16'hFFFF);
        wait_idle();
        write_register(CFG_WIDTH_LIMIT, 16'hFFFF);
        write_register(CFG_SPARE_A, 16'($urandom));
        write_register(CFG_SPARE_B, 16'($urandom));
        send_sample(1'b0, 8'd30, 16'd640, 16'd100);
        send_sample(1'b0, 8'd60, 16'd640, 16'hFFFF);
    endtask

    // Object longer than the sample counter: extra samples are not summed
    task automatic test_long_object();
        wait_idle();
        write_register(CFG_THRESHOLD, THRESHOLD_RESET);
        write_register(CFG_WIDTH_LIMIT, LIMIT_RESET);
        send_sample(1'b1, 8'd5, ping_roll(), outside_ir());
        repeat (258)
            send_sample(1'b0, 8'($urandom_range(180)), 16'($urandom), inside_ir());
        send_sample(1'b0, 8'($urandom_range(180)), ping_roll(), outside_ir());
    endtask

    // Over 255 objects in one sweep, with no idling on either side
    task automatic test_many_objects();
        wait_idle();
        write_register(CFG_THRESHOLD, 16'($urandom_range(5000, 1000)));
        write_register(CFG_WIDTH_LIMIT, 16'($urandom_range(60, 1)));
        idle_on = 1'b0;
        send_sample(1'b1, 8'd0, ping_roll(), outside_ir());
        repeat (260) begin
            send_sample(1'b0, 8'($urandom_range(180)), ping_roll(), inside_ir());
            send_sample(1'b0, 8'($urandom_range(180)), ping_roll(), outside_ir());
        end
        idle_on = 1'b1;
    endtask

    // Mostly well-formed objects along a sweep, with noise and broken objects
    task automatic test_random_sweeps();
        int start_count, pick;
        for (int round = 0; round < 2; round++) begin
            wait_idle();
            if (round == 0)
                write_register(CFG_THRESHOLD, 16'($urandom_range(65535, 1)));
            else
                write_register(CFG_THRESHOLD, 16'($urandom_range(4000, 200)));
            write_register(CFG_WIDTH_LIMIT,
                           $urandom_range(3) ? 16'($urandom_range(100)) : 16'($urandom));
            start_count = samples_sent;
            while (samples_sent - start_count < 70) begin
                pick = $urandom_range(99);
                if (pick < 75) begin
                    repeat ($urandom_range(2)) send_swept(ping_roll(), outside_ir());
                    repeat ($urandom_range(6, 1)) send_swept(ping_roll(), inside_ir());
                    send_swept(ping_roll(), outside_ir());
                end else if (pick < 88) begin
                    send_sample($urandom_range(7) == 0, 8'($urandom), 16'($urandom),
                                16'($urandom));
                end else begin
                    // open an object, then cut it off with a new sweep
                    repeat ($urandom_range(3, 1)) send_swept(ping_roll(), inside_ir());
                    sweep_ang = 8'($urandom_range(20));
                    send_sample(1'b1, sweep_ang, ping_roll(), 16'($urandom));
                end
            end
        end
    endtask

    initial begin
        i_rst_n          = 1'b0;
        i_in_valid       = 1'b0;
        i_first_of_sweep = 1'b0;
        i_angle          = '0;
        i_ping_distance  = '0;
        i_ir_distance    = '0;
        i_cfg_valid      = 1'b0;
        i_cfg_index      = '0;
        i_cfg_data       = '0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_defaults();
        test_span_cases();
        test_sweep_restart();
        test_register_extremes();
        test_long_object();
        test_many_objects();
        test_random_sweeps();
        wait_idle();

        // Anything still queued never arrived
        if (expected_segments.size() != 0) begin
            error_count += expected_segments.size();
            $display("%0t: %0d expected object items never arrived", $time,
                     expected_segments.size());
        end
        $display("Sent %0d sweep samples and checked %0d object items over %0d register writes",
                 samples_sent, segments_seen, register_writes);
        $display("Spans, angle clamping, sweep restarts, long objects and object overflow run");
        if (error_count == 0) begin
            $display("range_sweep_object_segmenter_test OK");
        end else begin
            $display("range_sweep_object_segmenter_test NOT OK");
        end
        $finish;
    end

endmodule
